[rtl/rpfs_pkg.sv]
package rpfs_pkg;

    localparam int REQ_W    = 3;
    localparam int VID_W    = 10;
    localparam int REG_W    = 3;
    localparam int STATUS_W = 3;

    // Ids are VID_W bits wide, so no more flags than this are ever addressed.
    localparam int VID_SPACE = 1 << VID_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP    = 3'd0,
        REQ_ALLOC     = 3'd1,
        REQ_RELEASE   = 3'd2,
        REQ_SPILL_ONE = 3'd3,
        REQ_SPILL_ALL = 3'd4,
        REQ_BIND      = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_SPILLED     = 3'd1,
        ST_UNKNOWN     = 3'd2,
        ST_POOL_FULL   = 3'd3,
        ST_NOT_MAPPED  = 3'd4,
        ST_NOTHING     = 3'd5,
        ST_ALREADY_MAP = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FRONT,
        S_SCAN,
        S_EXEC
    } t_state;

endpackage

[rtl/register_pool_fifo_spill.sv]
// Register pool allocator: hands POOL_SIZE physical registers to virtual
// register ids, keeps them in an age list and spills oldest-first. After
// reset the block clears its spilled-flag memory, one entry per cycle, for
// all min(VREG_COUNT, 1024) entries before it takes the first request. Each
// request then walks all POOL_SIZE registers through one shared id
// comparator, one register per cycle, so a request holds the input until its
// walk is done and its result is loaded; spill-all repeats that walk for
// every evicted id. The result sits in an output register, so the next
// request is taken while it waits to be transferred.
module register_pool_fifo_spill #(
    parameter int POOL_SIZE  = 5,
    parameter int VREG_COUNT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rpfs_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rpfs_pkg::VID_W-1:0]    i_vreg_id,
    input  logic [rpfs_pkg::REG_W-1:0]    i_bind_reg,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rpfs_pkg::STATUS_W-1:0] o_status,
    output logic [rpfs_pkg::REG_W-1:0]    o_phys_reg,
    output logic [rpfs_pkg::VID_W-1:0]    o_vreg_out,
    output logic                          o_last
);
    import rpfs_pkg::*;

    localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int BW = (PW > REG_W) ? PW : REG_W;
    localparam int FLAG_DEPTH = (VREG_COUNT < VID_SPACE) ? VREG_COUNT : VID_SPACE;
    localparam int AW = $clog2(FLAG_DEPTH);

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [VID_W-1:0]      r_key, n_key;
    logic [REG_W-1:0]      r_breg, n_breg;
    logic [PW-1:0]         r_idx, n_idx;
    logic                  r_hit_ok, n_hit_ok;
    logic [PW-1:0]         r_hit, n_hit;
    logic                  r_free_ok, n_free_ok;
    logic [PW-1:0]         r_free, n_free;
    logic [PW-1:0]         r_pos, n_pos;
    logic [POOL_SIZE-1:0]  r_busy, n_busy;
    logic [VID_W-1:0]      r_owner [POOL_SIZE];
    logic [VID_W-1:0]      n_owner [POOL_SIZE];
    logic [VID_W-1:0]      r_age [POOL_SIZE];
    logic [VID_W-1:0]      n_age [POOL_SIZE];
    logic [CW-1:0]         r_age_cnt, n_age_cnt;
    logic [AW-1:0]         r_clr, n_clr;

    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic [PW-1:0]         r_phys, n_phys;
    logic [VID_W-1:0]      r_vout, n_vout;
    logic                  r_last, n_last;

    // spilled flags: one write port, one registered read port
    logic                  r_flags [FLAG_DEPTH];
    logic                  r_flag;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic                  mem_wd;

    logic                  key_in_range;
    logic [BW-1:0]         breg_wide;
    logic [PW-1:0]         breg_idx;
    logic                  breg_bad;
    logic                  can_load;
    logic [BW-1:0]         phys_wide;

    assign key_in_range = 32'(r_key) < FLAG_DEPTH;
    assign breg_wide    = BW'(r_breg);
    assign breg_idx     = breg_wide[PW-1:0];
    assign breg_bad     = (32'(r_breg) >= POOL_SIZE) || r_busy[breg_idx];
    assign can_load     = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_flags[mem_wa] <= mem_wd;
        end
        r_flag <= r_flags[r_key[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_busy      <= '0;
            r_age_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_busy      <= n_busy;
            r_age_cnt   <= n_age_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_breg    <= n_breg;
        r_idx     <= n_idx;
        r_hit_ok  <= n_hit_ok;
        r_hit     <= n_hit;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_pos     <= n_pos;
        r_owner   <= n_owner;
        r_age     <= n_age;
        r_status  <= n_status;
        r_phys    <= n_phys;
        r_vout    <= n_vout;
        r_last    <= n_last;
    end

    always_comb begin
        logic          do_rm;
        logic [PW-1:0] rm_pos;
        logic          do_add;
        logic [PW-1:0] add_reg;
        logic [CW-1:0] cnt_dec;

        n_state     = r_state;
        n_req       = r_req;
        n_key       = r_key;
        n_breg      = r_breg;
        n_idx       = r_idx;
        n_hit_ok    = r_hit_ok;
        n_hit       = r_hit;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_pos       = r_pos;
        n_busy      = r_busy;
        n_owner     = r_owner;
        n_age       = r_age;
        n_age_cnt   = r_age_cnt;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_phys      = r_phys;
        n_vout      = r_vout;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_wa      = r_key[AW-1:0];
        mem_wd      = 1'b1;
        o_in_ready  = 1'b0;
        do_rm       = 1'b0;
        rm_pos      = '0;
        do_add      = 1'b0;
        add_reg     = '0;
        cnt_dec     = r_age_cnt - CW'(1);

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = 1'b0;
                n_clr  = r_clr + AW'(1);
                if (32'(r_clr) == FLAG_DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req     = t_req'(i_req_type);
                    n_breg    = i_bind_reg;
                    n_idx     = '0;
                    n_hit_ok  = 1'b0;
                    n_free_ok = 1'b0;
                    n_hit     = '0;
                    n_free    = '0;
                    n_pos     = '0;
                    if (t_req'(i_req_type) == REQ_SPILL_ONE ||
                        t_req'(i_req_type) == REQ_SPILL_ALL) begin
                        n_key = r_age[0];
                    end else begin
                        n_key = i_vreg_id;
                    end
                    n_state = S_SCAN;
                end
            end
            S_FRONT: begin
                n_key     = r_age[0];
                n_idx     = '0;
                n_hit_ok  = 1'b0;
                n_free_ok = 1'b0;
                n_hit     = '0;
                n_free    = '0;
                n_pos     = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // one register per cycle through the shared comparator
                if (!r_hit_ok && r_busy[r_idx] && r_owner[r_idx] == r_key) begin
                    n_hit_ok = 1'b1;
                    n_hit    = r_idx;
                end
                if (!r_free_ok && !r_busy[r_idx]) begin
                    n_free_ok = 1'b1;
                    n_free    = r_idx;
                end
                // ids in the age list are unique
                if (32'(r_idx) < 32'(r_age_cnt) && r_age[r_idx] == r_key) begin
                    n_pos = r_idx;
                end
                n_idx = r_idx + PW'(1);
                if (32'(r_idx) == POOL_SIZE - 1) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_vout      = r_key;
                    n_phys      = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    case (r_req)
                        REQ_LOOKUP: begin
                            if (r_hit_ok) begin
                                n_status = ST_OK;
                                n_phys   = r_hit;
                            end else if (key_in_range && r_flag) begin
                                n_status = ST_SPILLED;
                            end else begin
                                n_status = ST_UNKNOWN;
                            end
                        end
                        REQ_ALLOC: begin
                            if (r_hit_ok) begin
                                n_status = ST_ALREADY_MAP;
                                n_phys   = r_hit;
                            end else if (r_free_ok) begin
                                n_status = ST_OK;
                                n_phys   = r_free;
                                do_add   = 1'b1;
                                add_reg  = r_free;
                            end else begin
                                n_status = ST_POOL_FULL;
                            end
                        end
                        REQ_RELEASE: begin
                            if (r_hit_ok) begin
                                n_status       = ST_OK;
                                n_phys         = r_hit;
                                n_busy[r_hit]  = 1'b0;
                                do_rm          = 1'b1;
                                rm_pos         = r_pos;
                            end else begin
                                n_status = ST_NOT_MAPPED;
                            end
                        end
                        REQ_SPILL_ONE, REQ_SPILL_ALL: begin
                            if (r_age_cnt == '0) begin
                                n_status = ST_NOTHING;
                                n_vout   = '0;
                            end else begin
                                n_status = ST_SPILLED;
                                if (r_hit_ok) begin
                                    n_phys        = r_hit;
                                    n_busy[r_hit] = 1'b0;
                                end
                                mem_we = key_in_range;
                                do_rm  = 1'b1;
                                rm_pos = '0;
                                if (r_req == REQ_SPILL_ALL && cnt_dec != '0) begin
                                    n_last  = 1'b0;
                                    n_state = S_FRONT;
                                end
                            end
                        end
                        REQ_BIND: begin
                            if (r_hit_ok) begin
                                n_status = ST_ALREADY_MAP;
                                n_phys   = r_hit;
                            end else if (breg_bad) begin
                                n_status = ST_POOL_FULL;
                            end else begin
                                n_status = ST_OK;
                                n_phys   = breg_idx;
                                do_add   = 1'b1;
                                add_reg  = breg_idx;
                            end
                        end
                        default: begin
                            n_status = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // age list compaction and append
        if (do_rm) begin
            for (int j = 0; j < POOL_SIZE - 1; j++) begin
                if (PW'(j) >= rm_pos) begin
                    n_age[j] = r_age[j+1];
                end
            end
            n_age_cnt = cnt_dec;
        end
        if (do_add) begin
            n_busy[add_reg]  = 1'b1;
            n_owner[add_reg] = r_key;
            if (32'(r_age_cnt) < POOL_SIZE) begin
                n_age[r_age_cnt[PW-1:0]] = r_key;
                n_age_cnt = r_age_cnt + CW'(1);
            end
        end
    end

    assign phys_wide   = BW'(r_phys);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_phys_reg  = phys_wide[REG_W-1:0];
    assign o_vreg_out  = r_vout;
    assign o_last      = r_last;

endmodule

[sim/rpfs_checker.sv]
`timescale 1ns / 1ps

module rpfs_checker #(
    parameter int POOL_SIZE  = 5,
    parameter int VREG_COUNT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [rpfs_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rpfs_pkg::VID_W-1:0]    i_vreg_id,
    input  logic [rpfs_pkg::REG_W-1:0]    i_bind_reg,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rpfs_pkg::STATUS_W-1:0] i_status,
    input  logic [rpfs_pkg::REG_W-1:0]    i_phys_reg,
    input  logic [rpfs_pkg::VID_W-1:0]    i_vreg_out,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import rpfs_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REG_W-1:0]    preg;
        logic [VID_W-1:0]    vid;
        logic                last;
    } t_reply;

    // Shadow copy of the pool
    logic [VID_W-1:0] owner    [POOL_SIZE];
    logic             busy     [POOL_SIZE];
    logic             spilled  [VREG_COUNT];
    logic [VID_W-1:0] age_list [POOL_SIZE];
    int               age_n;

    t_reply pending_replies[$];
    t_reply got_reply;
    t_reply want_reply;
    int     fails;
    int     checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fails        = 0;
        checked      = 0;
        age_n        = 0;
    end

    function automatic int mapped_slot(input logic [VID_W-1:0] v);
        for (int r = 0; r < POOL_SIZE; r++)
            if (busy[r] && owner[r] == v)
                return r;
        return -1;
    endfunction

    function automatic void drop_from_age(input logic [VID_W-1:0] v);
        int j;
        j = 0;
        for (int i = 0; i < age_n; i++) begin
            if (age_list[i] != v) begin
                age_list[j] = age_list[i];
                j++;
            end
        end
        age_n = j;
    endfunction

    function automatic void push_reply(input logic [STATUS_W-1:0] status,
                                       input int preg,
                                       input logic [VID_W-1:0] vid,
                                       input logic last);
        t_reply rp;
        rp.status = status;
        rp.preg   = preg[REG_W-1:0];
        rp.vid    = vid;
        rp.last   = last;
        pending_replies = {pending_replies, rp};
    endfunction

    // Evicts the front of the age list; last is set when forced or list empties
    function automatic void evict_oldest(input logic force_last);
        logic [VID_W-1:0] v;
        int               r;
        v = age_list[0];
        r = mapped_slot(v);
        if (r >= 0)
            busy[r] = 1'b0;
        if (int'(v) < VREG_COUNT)
            spilled[v] = 1'b1;
        drop_from_age(v);
        push_reply(ST_SPILLED, (r < 0) ? 0 : r, v, force_last || (age_n == 0));
    endfunction

    function automatic void apply_pool_request(input logic [REQ_W-1:0] req,
                                               input logic [VID_W-1:0] vid,
                                               input logic [REG_W-1:0] breg);
        int r;
        int n;
        r = mapped_slot(vid);
        case (req)
            REQ_LOOKUP: begin
                if (r >= 0)
                    push_reply(ST_OK, r, vid, 1'b1);
                else if (int'(vid) < VREG_COUNT && spilled[vid])
                    push_reply(ST_SPILLED, 0, vid, 1'b1);
                else
                    push_reply(ST_UNKNOWN, 0, vid, 1'b1);
            end
            REQ_ALLOC: begin
                if (r >= 0) begin
                    push_reply(ST_ALREADY_MAP, r, vid, 1'b1);
                end else begin
                    for (int k = POOL_SIZE - 1; k >= 0; k--)
                        if (!busy[k])
                            r = k;
                    if (r < 0) begin
                        push_reply(ST_POOL_FULL, 0, vid, 1'b1);
                    end else begin
                        busy[r]  = 1'b1;
                        owner[r] = vid;
                        if (age_n < POOL_SIZE) begin
                            age_list[age_n] = vid;
                            age_n++;
                        end
                        push_reply(ST_OK, r, vid, 1'b1);
                    end
                end
            end
            REQ_RELEASE: begin
                if (r < 0) begin
                    push_reply(ST_NOT_MAPPED, 0, vid, 1'b1);
                end else begin
                    busy[r] = 1'b0;
                    drop_from_age(vid);
                    push_reply(ST_OK, r, vid, 1'b1);
                end
            end
            REQ_SPILL_ONE: begin
                if (age_n == 0)
                    push_reply(ST_NOTHING, 0, '0, 1'b1);
                else
                    evict_oldest(1'b1);
            end
            REQ_SPILL_ALL: begin
                if (age_n == 0) begin
                    push_reply(ST_NOTHING, 0, '0, 1'b1);
                end else begin
                    n = 0;
                    while (age_n > 0 && n < POOL_SIZE) begin
                        evict_oldest(1'b0);
                        n++;
                    end
                end
            end
            REQ_BIND: begin
                if (r >= 0) begin
                    push_reply(ST_ALREADY_MAP, r, vid, 1'b1);
                end else if (int'(breg) >= POOL_SIZE || busy[breg]) begin
                    push_reply(ST_POOL_FULL, 0, vid, 1'b1);
                end else begin
                    busy[breg]  = 1'b1;
                    owner[breg] = vid;
                    if (age_n < POOL_SIZE) begin
                        age_list[age_n] = vid;
                        age_n++;
                    end
                    push_reply(ST_OK, int'(breg), vid, 1'b1);
                end
            end
            default: push_reply(ST_UNKNOWN, 0, vid, 1'b1);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < POOL_SIZE; r++) begin
                busy[r]     = 1'b0;
                owner[r]    = '0;
                age_list[r] = '0;
            end
            for (int v = 0; v < VREG_COUNT; v++)
                spilled[v] = 1'b0;
            age_n = 0;
            pending_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_reply.status = i_status;
                got_reply.preg   = i_phys_reg;
                got_reply.vid    = i_vreg_out;
                got_reply.last   = i_last;
                if (pending_replies.size() == 0) begin
                    if (fails < 10)
                        $display("%t ERROR: unexpected reply status=%0d reg=%0d vid=%0d last=%0b",
                                 $realtime, got_reply.status, got_reply.preg,
                                 got_reply.vid, got_reply.last);
                    fails++;
                end else begin
                    want_reply = pending_replies.pop_front();
                    if (got_reply !== want_reply) begin
                        if (fails < 10) begin
                            $write("%t ERROR: reply exp st=%0d reg=%0d vid=%0d last=%0b",
                                   $realtime, want_reply.status, want_reply.preg,
                                   want_reply.vid, want_reply.last);
                            $display(", got st=%0d reg=%0d vid=%0d last=%0b",
                                     got_reply.status, got_reply.preg,
                                     got_reply.vid, got_reply.last);
                        end
                        fails++;
                    end
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                apply_pool_request(i_req_type, i_vreg_id, i_bind_reg);
        end
        o_fail_count <= fails;
        o_pending    <= pending_replies.size();
        o_checked    <= checked;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rpfs_pkg::*;

    localparam int POOL_SIZE  = 5;
    localparam int VREG_COUNT = 1024;
    localparam int PHASE_REQS = 108;
    localparam int HOT_IDS    = 12;

    // Request codes the block does not define
    localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [REQ_W-1:0]    i_req_type  = '0;
    logic [VID_W-1:0]    i_vreg_id   = '0;
    logic [REG_W-1:0]    i_bind_reg  = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [REG_W-1:0]    o_phys_reg;
    logic [VID_W-1:0]    o_vreg_out;
    logic                o_last;

    int               sender_idle_pct   = 8;
    int               receiver_idle_pct = 63;
    int               requests_sent     = 0;
    int               fail_count;
    int               replies_pending;
    int               replies_checked;
    logic [VID_W-1:0] hot_ids [HOT_IDS];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    register_pool_fifo_spill #(
        .POOL_SIZE  (POOL_SIZE),
        .VREG_COUNT (VREG_COUNT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_vreg_id   (i_vreg_id),
        .i_bind_reg  (i_bind_reg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_phys_reg  (o_phys_reg),
        .o_vreg_out  (o_vreg_out),
        .o_last      (o_last)
    );

    rpfs_checker #(
        .POOL_SIZE  (POOL_SIZE),
        .VREG_COUNT (VREG_COUNT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_vreg_id    (i_vreg_id),
        .i_bind_reg   (i_bind_reg),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (o_status),
        .i_phys_reg   (o_phys_reg),
        .i_vreg_out   (o_vreg_out),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (replies_pending),
        .o_checked    (replies_checked)
    );

    task automatic issue_request(input logic [REQ_W-1:0] req,
                                 input logic [VID_W-1:0] vid,
                                 input logic [REG_W-1:0] breg);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_vreg_id  <= vid;
        i_bind_reg <= breg;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    // Hold the sender off until every outstanding reply has transferred
    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_pending != 0)
            @(posedge i_clk);
    endtask

    task automatic random_request();
        int               pick;
        logic [REQ_W-1:0] req;
        logic [VID_W-1:0] vid;
        logic [REG_W-1:0] breg;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            req = REQ_LOOKUP;
        else if (pick < 44)
            req = REQ_ALLOC;
        else if (pick < 64)
            req = REQ_RELEASE;
        else if (pick < 74)
            req = REQ_SPILL_ONE;
        else if (pick < 80)
            req = REQ_SPILL_ALL;
        else if (pick < 95)
            req = REQ_BIND;
        else
            req = REQ_W'($urandom_range(REQ_RSVD_A, REQ_RSVD_B));
        // small working set keeps ids colliding in a five-entry pool
        if ($urandom_range(0, 99) < 80)
            vid = hot_ids[$urandom_range(0, HOT_IDS - 1)];
        else
            vid = VID_W'($urandom_range(0, VREG_COUNT - 1));
        if ($urandom_range(0, 99) < 85)
            breg = REG_W'($urandom_range(0, POOL_SIZE - 1));
        else
            breg = REG_W'($urandom_range(0, 7));
        issue_request(req, vid, breg);
    endtask

    initial begin
        hot_ids[0] = '0;
        hot_ids[1] = '1;
        for (int i = 2; i < HOT_IDS; i++)
            hot_ids[i] = VID_W'($urandom_range(0, VREG_COUNT - 1));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pool, refusals, full pool, spill paths
        issue_request(REQ_LOOKUP,    10'd0,    3'd0);
        issue_request(REQ_SPILL_ONE, 10'd0,    3'd0);
        issue_request(REQ_SPILL_ALL, 10'd1023, 3'd7);
        issue_request(REQ_RELEASE,   10'd5,    3'd0);
        issue_request(REQ_ALLOC,     10'd1023, 3'd0);
        issue_request(REQ_ALLOC,     10'd0,    3'd0);
        issue_request(REQ_ALLOC,     10'd0,    3'd0);
        issue_request(REQ_BIND,      10'd512,  3'd4);
        issue_request(REQ_BIND,      10'd300,  3'd1);
        issue_request(REQ_BIND,      10'd301,  3'd7);
        issue_request(REQ_BIND,      10'd302,  3'd5);
        issue_request(REQ_BIND,      10'd1023, 3'd2);
        issue_request(REQ_ALLOC,     10'd100,  3'd0);
        issue_request(REQ_ALLOC,     10'd200,  3'd0);
        issue_request(REQ_ALLOC,     10'd400,  3'd0);
        issue_request(REQ_LOOKUP,    10'd0,    3'd0);
        issue_request(REQ_RELEASE,   10'd0,    3'd0);
        issue_request(REQ_LOOKUP,    10'd0,    3'd0);
        issue_request(REQ_SPILL_ONE, 10'd0,    3'd0);
        issue_request(REQ_LOOKUP,    10'd1023, 3'd0);
        issue_request(REQ_RSVD_A,    10'd1023, 3'd7);
        issue_request(REQ_RSVD_B,    10'd0,    3'd0);
        issue_request(REQ_ALLOC,     10'd0,    3'd0);
        issue_request(REQ_SPILL_ALL, 10'd0,    3'd0);
        issue_request(REQ_LOOKUP,    10'd512,  3'd0);
        issue_request(REQ_RELEASE,   10'd1023, 3'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 8;
                    receiver_idle_pct = 63;
                end
                1: begin
                    sender_idle_pct   = 63;
                    receiver_idle_pct = 8;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_REQS; i++) begin
                if (i == PHASE_REQS / 2)
                    wait_replies_drained();
                random_request();
            end
        end

        wait_replies_drained();
        repeat (20) @(posedge i_clk);

        $display("Summary: %0d requests, %0d replies checked, %0d mismatches",
                 requests_sent, replies_checked, fail_count);
        $display("Covered all request kinds and unused codes under three flow-control mixes");
        if (fail_count == 0 && replies_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d requests sent, %0d replies outstanding",
                 requests_sent, replies_pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[register_pool_fifo_spill.f]
rtl/rpfs_pkg.sv
rtl/register_pool_fifo_spill.sv
sim/rpfs_checker.sv
sim/tb.sv
